// ----- hw/rtl/mdiv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Modular division package
// Shared constants, operation codes and the status record of the core.
// ----------------------------------------------------------------------------
package mdiv_pkg;

	localparam int OPERAND_BITS_DEF = 63;

	localparam logic [63:0] DEFAULT_MODULUS = 64'd1000000007;

	localparam logic MOP_ADD = 1'b0;
	localparam logic MOP_SUB = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
		logic no_inverse;
	} mdiv_stat_t;

endpackage : mdiv_pkg
`default_nettype wire

// ----- hw/rtl/mdiv_modadd.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Modular add/subtract unit
// Computes (x + y) mod m or (x - y) mod m for operands already below m.
// ----------------------------------------------------------------------------
module mdiv_modadd
	import mdiv_pkg::*;
#(
	parameter int W = OPERAND_BITS_DEF
) (
	input  wire logic         op,
	input  wire logic [W-1:0] x,
	input  wire logic [W-1:0] y,
	input  wire logic [W-1:0] m,
	output logic      [W-1:0] r
);

	logic [W-1:0] diff;

	always_comb begin
		diff = m - y;
		if (op == MOP_SUB) begin
			r = (x >= y) ? (x - y) : (x + diff);
		end else begin
			r = (x >= diff) ? (x - diff) : (x + y);
		end
	end

endmodule : mdiv_modadd
`default_nettype wire

// ----- hw/rtl/mdiv_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Modular division sequencer
// Reduces the operands, runs extended Euclid with bit-serial long division
// and Horner coefficient update, then forms the product, with all modular
// arithmetic through one shared modular adder.
// ----------------------------------------------------------------------------
module mdiv_core
	import mdiv_pkg::*;
#(
	parameter int W = OPERAND_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] numerator,
	input  wire logic [W-1:0] denominator,
	input  wire logic [W-1:0] modulus,
	output mdiv_stat_t        stat,
	output logic      [W-1:0] quotient
);

	localparam int KW = $clog2(W);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ALIGN = 3'd1;
	localparam logic [2:0] S_DBL   = 3'd2;
	localparam logic [2:0] S_ADD   = 3'd3;
	localparam logic [2:0] S_UPD   = 3'd4;
	localparam logic [2:0] S_CHK   = 3'd5;

	localparam logic [1:0] J_NUM = 2'd0;
	localparam logic [1:0] J_DEN = 2'd1;
	localparam logic [1:0] J_EUC = 2'd2;
	localparam logic [1:0] J_MUL = 2'd3;

	logic [2:0]    state_q;
	logic [1:0]    job_q;
	logic          done_q;
	logic          noinv_q;
	logic [W-1:0]  quot_q;
	logic [W-1:0]  num_q;
	logic [W-1:0]  den_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsh_q;
	logic [W-1:0]  r0_q;
	logic [W-1:0]  r1_q;
	logic [W-1:0]  t0_q;
	logic [W-1:0]  t1_q;
	logic [W-1:0]  acc_q;
	logic [KW-1:0] k_q;
	logic          bit_q;

	logic          accept;
	logic          div_bit;
	logic          next_bit;
	logic          align_go;
	logic          mop;
	logic [W-1:0]  mx;
	logic [W-1:0]  my;
	logic [W-1:0]  mr;
	logic [W-1:0]  acc_add;

	assign accept   = start && (state_q == S_IDLE);
	assign div_bit  = (rem_q >= dsh_q);
	assign next_bit = (job_q == J_MUL) ? num_q[k_q] : div_bit;
	assign align_go = ({dsh_q, 1'b0} <= {1'b0, rem_q});
	assign acc_add  = bit_q ? mr : acc_q;

	always_comb begin
		mop = MOP_ADD;
		mx  = acc_q;
		my  = acc_q;
		case (state_q)
			S_ADD: begin
				my = (job_q == J_MUL) ? t0_q : t1_q;
			end
			S_UPD: begin
				mop = MOP_SUB;
				mx  = t0_q;
				my  = acc_q;
			end
			default: begin
				mop = MOP_ADD;
			end
		endcase
	end

	mdiv_modadd #(
		.W (W)
	) u_modadd (
		.op (mop),
		.x  (mx),
		.y  (my),
		.m  (modulus),
		.r  (mr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= J_NUM;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (modulus == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_ALIGN;
							job_q   <= J_NUM;
						end
					end
				end
				S_ALIGN: begin
					if (!align_go) begin
						state_q <= S_DBL;
					end
				end
				S_DBL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (k_q == '0) begin
						case (job_q)
							J_NUM: begin
								job_q   <= J_DEN;
								state_q <= S_ALIGN;
							end
							J_DEN: begin
								state_q <= S_CHK;
							end
							J_EUC: begin
								state_q <= S_UPD;
							end
							default: begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						endcase
					end else begin
						state_q <= S_DBL;
					end
				end
				S_UPD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (r1_q == '0) begin
						if (r0_q != W'(1)) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							job_q   <= J_MUL;
							state_q <= S_DBL;
						end
					end else begin
						job_q   <= J_EUC;
						state_q <= S_ALIGN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					num_q   <= numerator;
					den_q   <= denominator;
					rem_q   <= numerator;
					dsh_q   <= modulus;
					k_q     <= '0;
					quot_q  <= '0;
					noinv_q <= 1'b1;
				end
			end
			S_ALIGN: begin
				if (align_go) begin
					dsh_q <= {dsh_q[W-2:0], 1'b0};
					k_q   <= k_q + KW'(1);
				end
			end
			S_DBL: begin
				if (job_q != J_MUL) begin
					if (div_bit) begin
						rem_q <= rem_q - dsh_q;
					end
					dsh_q <= dsh_q >> 1;
				end
				bit_q <= next_bit;
				acc_q <= mr;
			end
			S_ADD: begin
				acc_q <= acc_add;
				if (k_q == '0) begin
					case (job_q)
						J_NUM: begin
							num_q <= rem_q;
							rem_q <= den_q;
							dsh_q <= modulus;
						end
						J_DEN: begin
							r0_q <= modulus;
							r1_q <= rem_q;
							t0_q <= '0;
							t1_q <= W'(1);
						end
						J_EUC: begin
							r0_q <= r0_q;
						end
						default: begin
							quot_q  <= acc_add;
							noinv_q <= 1'b0;
						end
					endcase
				end else begin
					k_q <= k_q - KW'(1);
				end
			end
			S_UPD: begin
				r0_q <= r1_q;
				r1_q <= rem_q;
				t0_q <= t1_q;
				t1_q <= mr;
			end
			S_CHK: begin
				acc_q <= '0;
				if (r1_q == '0) begin
					k_q <= KW'(W - 1);
					if (r0_q != W'(1)) begin
						quot_q  <= '0;
						noinv_q <= 1'b1;
					end
				end else begin
					rem_q <= r0_q;
					dsh_q <= r1_q;
					k_q   <= '0;
				end
			end
			default: begin
				bit_q <= 1'b0;
			end
		endcase
	end

	assign stat.busy       = (state_q != S_IDLE);
	assign stat.done       = done_q;
	assign stat.no_inverse = noinv_q;
	assign quotient        = quot_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe raised while the sequencer was busy");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE) || done_q)
		else $error("accepted request neither started nor finished");

	a_align_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALIGN && k_q != '0) |-> (dsh_q <= rem_q))
		else $error("shifted divisor exceeds the partial remainder");

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> (acc_q < modulus) && (t0_q < modulus))
		else $error("Euclid coefficient not reduced below the modulus");

	a_chk_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALIGN && job_q == J_EUC) |-> (dsh_q != '0))
		else $error("Euclid step started with a zero divisor");

endmodule : mdiv_core
`default_nettype wire

// ----- hw/rtl/modular_division_ext_euclid_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Modular division by extended Euclid
// Returns numerator times the inverse of denominator modulo a programmable
// modulus, or zero with a flag when no inverse exists.
//
//   Channel   Signals                               Direction
//   request   start, busy, numerator, denominator   in (busy out)
//   result    done, quotient, no_inverse            out
//   config    cfg_wr_en, cfg_wr_data (modulus)      in
//
// A request is taken when start is high and busy is low; busy stays high
// until the result strobe. The latency is data dependent: each Euclid step
// runs a long division whose length grows with the bit length of its
// quotient, the two operand reductions work the same way, and the final
// product takes one step per operand bit. A zero modulus answers in the
// cycle after the request. All modular arithmetic runs through one shared
// modular adder. Reset loads the modulus 1000000007. The receiver cannot
// stall results.
// ----------------------------------------------------------------------------
module modular_division_ext_euclid_top
	import mdiv_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [OPERAND_BITS-1:0] numerator,
	input  wire logic [OPERAND_BITS-1:0] denominator,
	input  wire logic                    cfg_wr_en,
	input  wire logic [OPERAND_BITS-1:0] cfg_wr_data,
	output logic                         done,
	output logic      [OPERAND_BITS-1:0] quotient,
	output logic                         no_inverse
);

	logic [OPERAND_BITS-1:0] modulus_q;
	mdiv_stat_t              stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= DEFAULT_MODULUS[OPERAND_BITS-1:0];
		end else if (cfg_wr_en) begin
			modulus_q <= cfg_wr_data;
		end
	end

	mdiv_core #(
		.W (OPERAND_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.numerator   (numerator),
		.denominator (denominator),
		.modulus     (modulus_q),
		.stat        (stat),
		.quotient    (quotient)
	);

	assign busy       = stat.busy;
	assign done       = stat.done;
	assign no_inverse = stat.no_inverse;

endmodule : modular_division_ext_euclid_top
`default_nettype wire
